[src/b64sp_pkg.sv]
package b64sp_pkg;

    localparam int unsigned MaxResults = 5;
    localparam int unsigned CountW     = $clog2(MaxResults + 1);
    localparam int unsigned IdxW       = $clog2(MaxResults);

    localparam logic [1:0] CMD_ENC_BYTE = 2'd0;
    localparam logic [1:0] CMD_ENC_END  = 2'd1;
    localparam logic [1:0] CMD_DEC_CHAR = 2'd2;
    localparam logic [1:0] CMD_DEC_END  = 2'd3;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_BYTE = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] SYM_PAD    = 8'd64;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data;
    } in_word_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       run_last;
    } out_word_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
    } result_t;

    typedef struct packed {
        logic [CountW-1:0]               count;
        result_t [MaxResults-1:0]        res;
    } bundle_t;

    function automatic logic [7:0] enc_sym(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)
            return w + 8'd65;
        else if (v < 6'd52)
            return w + 8'd71;
        else if (v < 6'd62)
            return w - 8'd4;
        else if (v == 6'd62)
            return CHAR_PLUS;
        else
            return CHAR_SLASH;
    endfunction

    // 8-bit wrap on the out-of-range classes
    function automatic logic [7:0] dec_sym(input logic [7:0] c);
        if (c == CHAR_PLUS)
            return 8'd62;
        else if (c == CHAR_SLASH)
            return 8'd63;
        else if (c == CHAR_SPACE)
            return SYM_PAD;
        else if (c <= 8'h39)
            return c + 8'd4;
        else if (c <= 8'h5A)
            return c - 8'd65;
        else if (c <= 8'h7A)
            return c - 8'd71;
        else
            return SYM_PAD;
    endfunction

endpackage

[src/b64sp_group.sv]
module b64sp_group
    import b64sp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  in_word_t word,
    output bundle_t  bundle
);

    logic [23:0] buf_reg;
    logic [23:0] buf_next;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;

    logic [7:0] e0;
    logic [7:0] e1;
    logic [7:0] e2;
    logic [7:0] d;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] s0;
    logic [7:0] s1;
    logic [7:0] s2;
    logic [7:0] s3;

    assign e0 = buf_reg[23:16];
    assign e1 = buf_reg[15:8];
    assign e2 = buf_reg[7:0];
    assign d  = word.data;
    assign b1 = (fill_reg > 2'd1) ? e1 : 8'd0;
    assign b2 = (fill_reg > 2'd2) ? e2 : 8'd0;
    assign s0 = dec_sym(e0);
    assign s1 = dec_sym(e1);
    assign s2 = dec_sym(e2);
    assign s3 = dec_sym(d);

    always_comb
    begin
        bundle    = '0;
        buf_next  = buf_reg;
        fill_next = fill_reg;
        case (word.command)
            CMD_ENC_BYTE, CMD_DEC_CHAR:
            begin
                if (fill_reg != 2'd3)
                begin
                    fill_next = fill_reg + 2'd1;
                    case (fill_reg)
                        2'd0:    buf_next[23:16] = d;
                        2'd1:    buf_next[15:8]  = d;
                        default: buf_next[7:0]   = d;
                    endcase
                end
                else
                begin
                    buf_next  = '0;
                    fill_next = '0;
                    if (word.command == CMD_ENC_BYTE)
                    begin
                        bundle.count        = CountW'(4);
                        bundle.res[0].kind  = KIND_CHAR;
                        bundle.res[0].value = enc_sym(e0[7:2]);
                        bundle.res[1].kind  = KIND_CHAR;
                        bundle.res[1].value = enc_sym({e0[1:0], e1[7:4]});
                        bundle.res[2].kind  = KIND_CHAR;
                        bundle.res[2].value = enc_sym({e1[3:0], d[7:6]});
                        bundle.res[3].kind  = KIND_CHAR;
                        bundle.res[3].value = enc_sym(d[5:0]);
                    end
                    else
                    begin
                        bundle.res[0].kind  = KIND_BYTE;
                        bundle.res[0].value = {s0[5:0], 2'b00} | {4'b0000, s1[7:4]};
                        bundle.res[1].kind  = KIND_BYTE;
                        bundle.res[1].value = {s1[3:0], 4'b0000} | {2'b00, s2[7:2]};
                        bundle.res[2].kind  = KIND_BYTE;
                        bundle.res[2].value = {s2[1:0], 6'b000000} | s3;
                        if (s2 == SYM_PAD)
                            bundle.count = CountW'(1);
                        else if (s3 == SYM_PAD)
                            bundle.count = CountW'(2);
                        else
                            bundle.count = CountW'(3);
                    end
                end
            end
            CMD_ENC_END:
            begin
                buf_next  = '0;
                fill_next = '0;
                if (fill_reg != 2'd0)
                begin
                    bundle.count        = CountW'(5);
                    bundle.res[0].kind  = KIND_CHAR;
                    bundle.res[0].value = enc_sym(e0[7:2]);
                    bundle.res[1].kind  = KIND_CHAR;
                    bundle.res[1].value = enc_sym({e0[1:0], b1[7:4]});
                    bundle.res[2].kind  = KIND_CHAR;
                    bundle.res[2].value = (fill_reg > 2'd1) ?
                                          enc_sym({b1[3:0], b2[7:6]}) : CHAR_SPACE;
                    bundle.res[3].kind  = KIND_CHAR;
                    bundle.res[3].value = (fill_reg > 2'd2) ? enc_sym(b2[5:0]) : CHAR_SPACE;
                    bundle.res[4].kind  = KIND_CHAR;
                    bundle.res[4].value = CHAR_DASH;
                end
                else
                begin
                    bundle.count        = CountW'(1);
                    bundle.res[0].kind  = KIND_CHAR;
                    bundle.res[0].value = CHAR_DASH;
                end
            end
            default:
            begin
                buf_next            = '0;
                fill_next           = '0;
                bundle.count        = CountW'(1);
                bundle.res[0].kind  = KIND_END;
                bundle.res[0].value = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg  <= '0;
            fill_reg <= '0;
        end
        else if (take)
        begin
            buf_reg  <= buf_next;
            fill_reg <= fill_next;
        end
    end

endmodule

[src/base64_space_pad_codec.sv]
// Streaming base64 codec, space-padded variant.
// Input channel (in_valid/in_ready/in_word): one command word per handshake,
// encode byte, encode end, decode character or decode end.
// Output channel (out_valid/out_ready/out_word): one result word per
// handshake; run_last marks the final word caused by an input word.
// A word that completes a group or ends a message leaves its results in a
// result bundle, which is registered into the output bundle register or,
// while that one is busy, into the waiting one; the results are offered one
// per cycle while out_ready is held. Words that only fill the group give none.
// A full encode group (4 byte words in, 4 characters out) gives 4 words;
// an end of encode with a partial group gives 5 words.
// Two bundle registers (one draining, one waiting) decouple the sides; the
// input stalls only when both are held. in_ready is a register output.
// When the receiver stalls, the current word holds and input keeps flowing
// until the waiting bundle register is filled.
// Reset clears the group buffer and empties both bundle registers.
module base64_space_pad_codec
    import b64sp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    bundle_t           new_bundle;
    logic              in_take;
    logic              new_has;

    bundle_t           o_bundle_reg;
    bundle_t           o_bundle_next;
    logic              o_valid_reg;
    logic              o_valid_next;
    logic [IdxW-1:0]   o_idx_reg;
    logic [IdxW-1:0]   o_idx_next;

    bundle_t           b_bundle_reg;
    bundle_t           b_bundle_next;
    logic              b_valid_reg;
    logic              b_valid_next;

    logic              o_last;
    logic              o_fire;
    logic              o_free;

    assign in_ready = !b_valid_reg;
    assign in_take  = in_valid && in_ready;
    assign new_has  = in_take && (new_bundle.count != '0);

    b64sp_group u_group (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (in_take),
        .word   (in_word),
        .bundle (new_bundle)
    );

    assign o_last             = (CountW'(o_idx_reg) == (o_bundle_reg.count - CountW'(1)));
    assign out_valid          = o_valid_reg;
    assign out_word.kind      = o_bundle_reg.res[o_idx_reg].kind;
    assign out_word.value     = o_bundle_reg.res[o_idx_reg].value;
    assign out_word.run_last  = o_last;
    assign o_fire             = o_valid_reg && out_ready;
    assign o_free             = !o_valid_reg || (o_fire && o_last);

    always_comb
    begin
        o_bundle_next = o_bundle_reg;
        o_valid_next  = o_valid_reg;
        o_idx_next    = o_idx_reg;
        b_bundle_next = b_bundle_reg;
        b_valid_next  = b_valid_reg;
        if (o_free)
        begin
            o_idx_next = '0;
            if (b_valid_reg)
            begin
                o_bundle_next = b_bundle_reg;
                o_valid_next  = 1'b1;
                b_valid_next  = 1'b0;
            end
            else if (new_has)
            begin
                o_bundle_next = new_bundle;
                o_valid_next  = 1'b1;
            end
            else
            begin
                o_valid_next = 1'b0;
            end
        end
        else
        begin
            if (o_fire)
                o_idx_next = o_idx_reg + IdxW'(1);
            if (new_has)
            begin
                b_bundle_next = new_bundle;
                b_valid_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
            o_idx_reg   <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            o_valid_reg <= o_valid_next;
            o_idx_reg   <= o_idx_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        o_bundle_reg <= o_bundle_next;
        b_bundle_reg <= b_bundle_next;
    end

    a_wait_implies_busy: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> o_valid_reg)
        else $error("waiting bundle held while output bundle empty");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg |-> (CountW'(o_idx_reg) < o_bundle_reg.count))
        else $error("output index beyond bundle count");

    a_bundle_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (b_bundle_reg.count != '0))
        else $error("empty bundle queued");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_word.kind == KIND_END)) |-> out_word.run_last)
        else $error("end marker not last word of its run");

    a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !o_free) |=> b_valid_reg)
        else $error("waiting bundle lost while output busy");

endmodule

[tb/tb_base64_space_pad_codec.sv]
module tb_base64_space_pad_codec;
    import b64sp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 180;
    localparam int DRAIN_CYCLES = 16;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_word_t  in_word = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_word;

    base64_space_pad_codec dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [23:0] grp_bytes = '0;
    logic [1:0]  grp_count = '0;
    out_word_t   due_words[$];

    int        error_count = 0;
    int        cycle_count = 0;
    int        sent_words = 0;
    int        burst_left = 0;
    bit        steady_feed = 1'b0;
    out_word_t want;

    logic [1:0] ready_mode = '0;
    logic [7:0] ready_mask = 8'hff;
    logic [5:0] ready_phase = '0;

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        if (v < 6'd26)
            return 8'h41 + {2'b00, v};
        if (v < 6'd52)
            return 8'h61 + ({2'b00, v} - 8'd26);
        if (v < 6'd62)
            return 8'h30 + ({2'b00, v} - 8'd52);
        return (v == 6'd62) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    // out-of-range classes wrap in 8 bits
    function automatic logic [7:0] b64_symbol(input logic [7:0] c);
        if (c == CHAR_PLUS)
            return 8'd62;
        if (c == CHAR_SLASH)
            return 8'd63;
        if (c == CHAR_SPACE)
            return SYM_PAD;
        if (c <= 8'h39)
            return c + 8'd4;
        if (c <= 8'h5A)
            return c - 8'h41;
        if (c <= 8'h7A)
            return c - 8'h61 + 8'd26;
        return SYM_PAD;
    endfunction

    function automatic out_word_t make_result(input logic [1:0] kind, input logic [7:0] value);
        out_word_t r;
        r.kind = kind;
        r.value = value;
        r.run_last = 1'b0;
        return r;
    endfunction

    function automatic void codec_step(input in_word_t w);
        out_word_t   made[$];
        logic [7:0]  d;
        logic [7:0]  b0, b1, b2, p1, p2;
        logic [7:0]  s0, s1, s2, s3;
        d = w.data;
        b0 = grp_bytes[23:16];
        b1 = grp_bytes[15:8];
        b2 = grp_bytes[7:0];
        case (w.command)
            CMD_ENC_BYTE, CMD_DEC_CHAR:
            begin
                if (grp_count != 2'd3) begin
                    grp_bytes[(16 - 8 * int'(grp_count)) +: 8] = d;
                    grp_count = grp_count + 2'd1;
                    return;
                end
                if (w.command == CMD_ENC_BYTE) begin
                    made.push_back(make_result(KIND_CHAR, b64_char(b0[7:2])));
                    made.push_back(make_result(KIND_CHAR, b64_char({b0[1:0], b1[7:4]})));
                    made.push_back(make_result(KIND_CHAR, b64_char({b1[3:0], d[7:6]})));
                    made.push_back(make_result(KIND_CHAR, b64_char(d[5:0])));
                end
                else begin
                    s0 = b64_symbol(b0);
                    s1 = b64_symbol(b1);
                    s2 = b64_symbol(b2);
                    s3 = b64_symbol(d);
                    made.push_back(make_result(KIND_BYTE, {s0[5:0], 2'b00} | {4'b0, s1[7:4]}));
                    if (s2 != SYM_PAD) begin
                        made.push_back(make_result(KIND_BYTE,
                                                   {s1[3:0], 4'b0} | {2'b00, s2[7:2]}));
                        if (s3 != SYM_PAD)
                            made.push_back(make_result(KIND_BYTE, {s2[1:0], 6'b0} | s3));
                    end
                end
            end
            CMD_ENC_END:
            begin
                if (grp_count != 2'd0) begin
                    p1 = (grp_count > 2'd1) ? b1 : 8'h00;
                    p2 = (grp_count > 2'd2) ? b2 : 8'h00;
                    made.push_back(make_result(KIND_CHAR, b64_char(b0[7:2])));
                    made.push_back(make_result(KIND_CHAR, b64_char({b0[1:0], p1[7:4]})));
                    made.push_back(make_result(KIND_CHAR, (grp_count > 2'd1) ?
                                               b64_char({p1[3:0], p2[7:6]}) : CHAR_SPACE));
                    made.push_back(make_result(KIND_CHAR, (grp_count > 2'd2) ?
                                               b64_char(p2[5:0]) : CHAR_SPACE));
                end
                made.push_back(make_result(KIND_CHAR, CHAR_DASH));
            end
            default:
                made.push_back(make_result(KIND_END, 8'h00));
        endcase
        grp_bytes = '0;
        grp_count = '0;
        made[made.size() - 1].run_last = 1'b1;
        foreach (made[i])
            due_words.push_back(made[i]);
    endfunction

    task automatic send_word(input logic [1:0] cmd, input logic [7:0] data);
        in_word_t w;
        int       gap;
        w.command = cmd;
        w.data = data;
        if (burst_left == 0) begin
            gap = (steady_feed || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        codec_step(w);
        sent_words++;
    endtask

    task automatic test_encode_groups();
        send_word(CMD_ENC_END, 8'h00);
        send_word(CMD_ENC_BYTE, 8'hff);
        send_word(CMD_ENC_BYTE, 8'h00);
        send_word(CMD_ENC_END, 8'hff);
        send_word(CMD_ENC_BYTE, 8'h12);
        send_word(CMD_ENC_BYTE, 8'h34);
        send_word(CMD_ENC_BYTE, 8'h56);
        send_word(CMD_ENC_END, 8'h00);
        send_word(CMD_ENC_BYTE, 8'h00);
        send_word(CMD_ENC_BYTE, 8'hff);
        send_word(CMD_ENC_BYTE, 8'hff);
        send_word(CMD_ENC_BYTE, 8'ha5);
    endtask

    task automatic test_decode_groups();
        send_word(CMD_DEC_CHAR, CHAR_PLUS);
        send_word(CMD_DEC_CHAR, CHAR_SLASH);
        send_word(CMD_DEC_CHAR, 8'h39);
        send_word(CMD_DEC_CHAR, 8'h5A);
        // third position pad cuts to one byte
        send_word(CMD_DEC_CHAR, 8'h3A);
        send_word(CMD_DEC_CHAR, 8'hff);
        send_word(CMD_DEC_CHAR, CHAR_SPACE);
        send_word(CMD_DEC_CHAR, 8'h7A);
        // fourth position pad cuts to two bytes
        send_word(CMD_DEC_CHAR, 8'h40);
        send_word(CMD_DEC_CHAR, 8'h7A);
        send_word(CMD_DEC_CHAR, 8'h61);
        send_word(CMD_DEC_CHAR, CHAR_SPACE);
        send_word(CMD_DEC_END, 8'hff);
    endtask

    task automatic test_mixed_groups();
        send_word(CMD_DEC_CHAR, 8'h71);
        send_word(CMD_ENC_END, 8'h00);
        send_word(CMD_ENC_BYTE, 8'h7f);
        send_word(CMD_DEC_END, 8'h00);
    endtask

    task automatic test_random_stream();
        int start;
        int n;
        int pad;
        int scenario;
        logic [7:0] ch;
        start = sent_words;
        while (sent_words - start < RANDOM_WORDS) begin
            scenario = $urandom_range(0, 9);
            steady_feed = ($urandom_range(0, 4) == 0);
            if (scenario < 4) begin
                n = $urandom_range(0, 11);
                repeat (n)
                    send_word(CMD_ENC_BYTE, 8'($urandom));
                send_word(CMD_ENC_END, 8'($urandom));
            end
            else if (scenario < 8) begin
                n = $urandom_range(0, 3);
                repeat (n) begin
                    pad = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
                    for (int i = 0; i < 4; i++) begin
                        ch = b64_char(6'($urandom));
                        if ($urandom_range(0, 7) == 0)
                            ch = 8'($urandom);
                        if (i >= 4 - pad)
                            ch = CHAR_SPACE;
                        send_word(CMD_DEC_CHAR, ch);
                    end
                end
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3))
                        send_word(CMD_DEC_CHAR, b64_char(6'($urandom)));
                send_word(CMD_DEC_END, 8'($urandom));
            end
            else begin
                repeat ($urandom_range(1, 5))
                    send_word(2'($urandom), 8'($urandom));
            end
        end
        steady_feed = 1'b0;
    endtask

    // receiver stall pattern, reshuffled each time ready_phase counts down to zero
    always @(posedge clk) begin
        if (ready_phase == 6'd0) begin
            ready_mode <= 2'($urandom_range(0, 3));
            ready_mask <= 8'($urandom) | 8'h01;
            ready_phase <= 6'd47;
        end
        else begin
            ready_phase <= ready_phase - 6'd1;
        end
        case (ready_mode)
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= ready_mask[ready_phase[2:0]];
            2'd2:    out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (due_words.size() == 0) begin
                flag_mismatch($sformatf("unexpected word kind=%0d value=%h last=%0b",
                                        out_word.kind, out_word.value, out_word.run_last));
            end
            else begin
                want = due_words.pop_front();
                if (out_word.kind !== want.kind)
                    flag_mismatch($sformatf("kind %0d, expected %0d", out_word.kind, want.kind));
                if (out_word.value !== want.value)
                    flag_mismatch($sformatf("value %h, expected %h", out_word.value, want.value));
                if (out_word.run_last !== want.run_last)
                    flag_mismatch($sformatf("run_last %0b, expected %0b",
                                            out_word.run_last, want.run_last));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_encode_groups();
        test_decode_groups();
        test_mixed_groups();
        test_random_stream();
        in_valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (due_words.size() != 0)
            flag_mismatch($sformatf("%0d words never arrived", due_words.size()));
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
